// ----- hw/rtl/tcwc_pkg.sv -----
// ----------------------------------------------------------------------------
// TCP congestion window control - shared package
// Types, constants and the microcode table of the control sequencer.
// ----------------------------------------------------------------------------
package tcwc_pkg;

    // Field widths
    localparam int ACK_W    = 32;
    localparam int SAMPLE_W = 24;
    localparam int WOUT_W   = 25;
    localparam int SLOTS_W  = 9;
    localparam int THR_W    = 9;
    localparam int TMO_W    = 27;
    localparam int DEV_CW   = 24;
    localparam int RTT_W    = 27;   // microseconds with 3 fraction bits
    localparam int ACC_W    = 31;   // shared accumulator of the RTT datapath
    localparam int IN_W     = 64;
    localparam int OUT_W    = 104;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 27;

    // Window parameter default
    localparam int WINDOW_MAX_DEF = 256;

    // Reset values and limits
    localparam logic [THR_W-1:0] THRESH_RST  = 9'd64;
    localparam logic [THR_W-1:0] THRESH_MIN  = 9'd2;
    localparam logic [THR_W-1:0] THRESH_MAX  = 9'd256;
    localparam logic [TMO_W-1:0] TMO_RST     = 27'd3000000;
    localparam logic [TMO_W-1:0] TMO_MAX     = 27'h7FFFFFF;
    localparam logic [RTT_W-1:0] DEV_RST     = 27'd160000;   // 20000 us * 8
    localparam int               ONE_PKT     = 65536;

    // Reciprocal divider: quotient bits of 2^32 / window, window >= 2^16
    localparam int QUO_W     = 17;
    localparam int DIV_CNT_W = 5;
    localparam int REM_INIT  = 32768;   // remainder after the leading zero bits

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEVIATION = 2'd2;

    // Microcode
    localparam int PC_W = 5;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_GROW_AV,
        OP_GROW_SS,
        OP_HIST,
        OP_CLR_HIST,
        OP_COLLAPSE,
        OP_EST_FIRST,
        OP_EST_A,
        OP_EST_B,
        OP_DEV_A,
        OP_DEV_B,
        OP_TMO_A,
        OP_TMO_B,
        OP_OUT
    } t_op;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_ITEM,
        C_KIND,
        C_SLOW,
        C_DIV_MORE,
        C_NOT_TRIPLE,
        C_NO_DUP,
        C_NO_SAMPLE,
        C_EST_VALID,
        C_OUT_BUSY
    } t_cond;

    typedef struct packed {
        t_op              op;
        t_cond            cond;
        logic [PC_W-1:0]  target;
    } t_uword;

    // Status from datapath to sequencer
    typedef struct packed {
        logic item_in;
        logic kind;
        logic slow;
        logic div_more;
        logic triple;
        logic dup;
        logic sample;
        logic est_valid;
        logic out_busy;
    } t_flags;

    // Control from sequencer to datapath
    typedef struct packed {
        t_op  op;
        logic idle;
    } t_ctrl;

    // Program entry points
    localparam logic [PC_W-1:0] P_IDLE  = 5'd0;
    localparam logic [PC_W-1:0] P_DIV   = 5'd3;
    localparam logic [PC_W-1:0] P_GSS   = 5'd5;
    localparam logic [PC_W-1:0] P_HIST  = 5'd6;
    localparam logic [PC_W-1:0] P_COLL  = 5'd9;
    localparam logic [PC_W-1:0] P_RTT   = 5'd10;
    localparam logic [PC_W-1:0] P_EWMA  = 5'd13;
    localparam logic [PC_W-1:0] P_TMO   = 5'd17;
    localparam logic [PC_W-1:0] P_OUT   = 5'd19;

    // Control store: op, jump condition, jump target (else fall through)
    function automatic t_uword urom(input logic [PC_W-1:0] pc);
        t_uword w;
        unique case (pc)
            5'd0:  w = '{OP_NOP,       C_NO_ITEM,    P_IDLE};
            5'd1:  w = '{OP_NOP,       C_KIND,       P_COLL};
            5'd2:  w = '{OP_DIV_INIT,  C_SLOW,       P_GSS};
            5'd3:  w = '{OP_DIV_STEP,  C_DIV_MORE,   P_DIV};
            5'd4:  w = '{OP_GROW_AV,   C_ALWAYS,     P_HIST};
            5'd5:  w = '{OP_GROW_SS,   C_NEVER,      P_IDLE};
            5'd6:  w = '{OP_HIST,      C_NEVER,      P_IDLE};
            5'd7:  w = '{OP_NOP,       C_NOT_TRIPLE, P_RTT};
            5'd8:  w = '{OP_CLR_HIST,  C_NO_DUP,     P_OUT};
            5'd9:  w = '{OP_COLLAPSE,  C_ALWAYS,     P_OUT};
            5'd10: w = '{OP_NOP,       C_NO_SAMPLE,  P_OUT};
            5'd11: w = '{OP_NOP,       C_EST_VALID,  P_EWMA};
            5'd12: w = '{OP_EST_FIRST, C_ALWAYS,     P_TMO};
            5'd13: w = '{OP_EST_A,     C_NEVER,      P_IDLE};
            5'd14: w = '{OP_EST_B,     C_NEVER,      P_IDLE};
            5'd15: w = '{OP_DEV_A,     C_NEVER,      P_IDLE};
            5'd16: w = '{OP_DEV_B,     C_NEVER,      P_IDLE};
            5'd17: w = '{OP_TMO_A,     C_NEVER,      P_IDLE};
            5'd18: w = '{OP_TMO_B,     C_NEVER,      P_IDLE};
            5'd19: w = '{OP_OUT,       C_OUT_BUSY,   P_OUT};
            5'd20: w = '{OP_NOP,       C_ALWAYS,     P_IDLE};
            default: w = '{OP_NOP,     C_ALWAYS,     P_IDLE};
        endcase
        return w;
    endfunction

endpackage

// ----- hw/rtl/tcp_congestion_window_control.sv -----
// Items are taken one at a time: intake opens only while the sequencer is
// idle, and the result is stored, after any output stall, before it returns.
// The 17-step reciprocal divider for avoidance growth sets the worst case
// of an item's work, the microcode step count the rest.
// Reset (synchronous, active low) loads the register defaults: window one
// packet, threshold 64, timeout 3000000 us, deviation 20000 us, history empty.
// ----------------------------------------------------------------------------
// TCP congestion window control - top level
// Tahoe style window and threshold control with fast retransmit detection
// and smoothed RTT / retransmission timeout estimation, driven by microcode.
// ----------------------------------------------------------------------------
module tcp_congestion_window_control #(
    parameter int WINDOW_MAX = tcwc_pkg::WINDOW_MAX_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Event items
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [31:0] ack_number, [55:32] rtt_sample_us, [56] sample_valid,
    // [57] dup_outstanding, [63:58] zero
    input  logic [tcwc_pkg::IN_W-1:0]        s_axis_tdata,
    // [0] kind
    input  logic                             s_axis_tuser,
    // Result items
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [24:0] window_q16, [33:25] window_slots, [42:34] threshold, [43] phase,
    // [44] retransmit, [76:45] retransmit_seq, [103:77] timeout_us
    output logic [tcwc_pkg::OUT_W-1:0]       m_axis_tdata,
    // Configuration writes
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [tcwc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [tcwc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int WIN_W = $clog2(WINDOW_MAX) + 17;
    localparam int CMP_W = (WIN_W + 1 > 25) ? WIN_W + 1 : 25;
    localparam logic [WIN_W:0] CAP = (WIN_W + 1)'(WINDOW_MAX) << 16;
    localparam logic [WIN_W-1:0] ONE_W = WIN_W'(tcwc_pkg::ONE_PKT);

    // Control
    tcwc_pkg::t_flags flags;
    tcwc_pkg::t_ctrl  ctrl;
    logic             in_acc;

    // Latched item
    logic                             r_kind;
    logic [tcwc_pkg::ACK_W-1:0]       r_ack;
    logic [tcwc_pkg::SAMPLE_W-1:0]    r_sample;
    logic                             r_svalid;
    logic                             r_dup;

    // Congestion state
    logic [WIN_W-1:0]                 r_window;
    logic [tcwc_pkg::THR_W-1:0]       r_limit;
    logic                             r_phase;
    logic [2:0]                       r_hvalid;
    logic [tcwc_pkg::ACK_W-1:0]       r_hack [3];
    logic                             r_triple;
    logic                             r_rexmit;

    // RTT state
    logic [tcwc_pkg::RTT_W-1:0]       r_est;
    logic                             r_est_valid;
    logic [tcwc_pkg::RTT_W-1:0]       r_dev;
    logic [tcwc_pkg::TMO_W-1:0]       r_timeout;
    logic [tcwc_pkg::ACC_W-1:0]       r_acc;
    logic [tcwc_pkg::RTT_W-1:0]       r_diff;

    // Divider
    logic [WIN_W-1:0]                 r_rem;
    logic [tcwc_pkg::QUO_W-1:0]       r_quo;
    logic [tcwc_pkg::DIV_CNT_W-1:0]   r_div_cnt;

    // Output stage
    logic                             r_out_valid;
    logic [tcwc_pkg::OUT_W-1:0]       r_out_data;

    // Datapath combinational values
    logic [WIN_W:0]                   rem2;
    logic                             rem_ge;
    logic [WIN_W:0]                   sum_av;
    logic [WIN_W:0]                   sum_ss;
    logic [WIN_W-1:0]                 win_av;
    logic [WIN_W-1:0]                 win_ss;
    logic                             ss_done;
    logic [CMP_W-1:0]                 half_w;
    logic [tcwc_pkg::THR_W-1:0]       coll_thr;
    logic [tcwc_pkg::RTT_W-1:0]       s8;
    logic [tcwc_pkg::TMO_W:0]         tmo_raw;
    logic [tcwc_pkg::TMO_W-1:0]       tmo_clamped;
    logic [tcwc_pkg::THR_W-1:0]       cfg_thr;
    logic [tcwc_pkg::TMO_W-1:0]       cfg_tmo;
    logic                             out_free;

    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = ctrl.idle;
    assign o_cfg_ready   = 1'b1;
    assign out_free      = !r_out_valid || m_axis_tready;

    // Sequencer status
    always_comb begin
        flags.item_in   = in_acc;
        flags.kind      = r_kind;
        flags.slow      = !r_phase;
        flags.div_more  = (r_div_cnt != '0);
        flags.triple    = r_triple;
        flags.dup       = r_dup;
        flags.sample    = r_svalid;
        flags.est_valid = r_est_valid;
        flags.out_busy  = !out_free;
    end

    tcwc_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_ctrl  (ctrl)
    );

    // Divider step, growth with saturation, collapse threshold
    always_comb begin
        rem2   = {r_rem, 1'b0};
        rem_ge = (rem2 >= (WIN_W + 1)'(r_window));
        sum_av = (WIN_W + 1)'(r_window) + (WIN_W + 1)'(r_quo);
        sum_ss = (WIN_W + 1)'(r_window) + (WIN_W + 1)'(ONE_W);
        win_av = (sum_av > CAP) ? WIN_W'(CAP) : WIN_W'(sum_av);
        win_ss = (sum_ss > CAP) ? WIN_W'(CAP) : WIN_W'(sum_ss);
        ss_done = (CMP_W'(win_ss) >= CMP_W'({r_limit, 16'b0}));
        half_w = CMP_W'(r_window >> 17);
        if (half_w < CMP_W'(tcwc_pkg::THRESH_MIN)) begin
            coll_thr = tcwc_pkg::THRESH_MIN;
        end else if (half_w > CMP_W'(tcwc_pkg::THRESH_MAX)) begin
            coll_thr = tcwc_pkg::THRESH_MAX;
        end else begin
            coll_thr = tcwc_pkg::THR_W'(half_w);
        end
    end

    // RTT helpers and configuration clamps
    always_comb begin
        s8      = {r_sample, 3'b000};
        tmo_raw = (tcwc_pkg::TMO_W + 1)'(r_acc >> 3);
        if (tmo_raw == '0) begin
            tmo_clamped = tcwc_pkg::TMO_W'(1);
        end else if (tmo_raw > (tcwc_pkg::TMO_W + 1)'(tcwc_pkg::TMO_MAX)) begin
            tmo_clamped = tcwc_pkg::TMO_MAX;
        end else begin
            tmo_clamped = tcwc_pkg::TMO_W'(tmo_raw);
        end
        cfg_thr = i_cfg_data[tcwc_pkg::THR_W-1:0];
        if (cfg_thr < tcwc_pkg::THRESH_MIN) begin
            cfg_thr = tcwc_pkg::THRESH_MIN;
        end else if (cfg_thr > tcwc_pkg::THRESH_MAX) begin
            cfg_thr = tcwc_pkg::THRESH_MAX;
        end
        cfg_tmo = i_cfg_data[tcwc_pkg::TMO_W-1:0];
        if (cfg_tmo == '0) begin
            cfg_tmo = tcwc_pkg::TMO_W'(1);
        end
    end

    // Item capture
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_kind   <= s_axis_tuser;
            r_ack    <= s_axis_tdata[31:0];
            r_sample <= s_axis_tdata[55:32];
            r_svalid <= s_axis_tdata[56];
            r_dup    <= s_axis_tdata[57];
        end
    end

    // Datapath executed under microcode control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window    <= ONE_W;
            r_limit     <= tcwc_pkg::THRESH_RST;
            r_phase     <= 1'b0;
            r_hvalid    <= '0;
            r_triple    <= 1'b0;
            r_rexmit    <= 1'b0;
            r_est       <= '0;
            r_est_valid <= 1'b0;
            r_dev       <= tcwc_pkg::DEV_RST;
            r_timeout   <= tcwc_pkg::TMO_RST;
            r_div_cnt   <= '0;
        end else begin
            if (in_acc) begin
                r_rexmit <= 1'b0;
            end
            case (ctrl.op)
                tcwc_pkg::OP_DIV_INIT: begin
                    r_rem     <= WIN_W'(tcwc_pkg::REM_INIT);
                    r_quo     <= '0;
                    r_div_cnt <= tcwc_pkg::DIV_CNT_W'(tcwc_pkg::QUO_W - 1);
                end
                tcwc_pkg::OP_DIV_STEP: begin
                    r_rem     <= rem_ge ? WIN_W'(rem2 - (WIN_W + 1)'(r_window))
                                        : WIN_W'(rem2);
                    r_quo     <= {r_quo[tcwc_pkg::QUO_W-2:0], rem_ge};
                    r_div_cnt <= r_div_cnt - 1'b1;
                end
                tcwc_pkg::OP_GROW_AV: begin
                    r_window <= win_av;
                end
                tcwc_pkg::OP_GROW_SS: begin
                    r_window <= win_ss;
                    if (ss_done) begin
                        r_phase <= 1'b1;
                    end
                end
                tcwc_pkg::OP_HIST: begin
                    r_hvalid  <= {1'b1, r_hvalid[2:1]};
                    r_hack[0] <= r_hack[1];
                    r_hack[1] <= r_hack[2];
                    r_hack[2] <= r_ack;
                    r_triple  <= r_hvalid[1] && r_hvalid[2] &&
                                 (r_hack[1] == r_hack[2]) && (r_hack[2] == r_ack);
                end
                tcwc_pkg::OP_CLR_HIST: begin
                    r_hvalid <= '0;
                end
                tcwc_pkg::OP_COLLAPSE: begin
                    r_limit  <= coll_thr;
                    r_window <= ONE_W;
                    r_phase  <= 1'b0;
                    r_rexmit <= !r_kind;
                end
                tcwc_pkg::OP_EST_FIRST: begin
                    r_est       <= s8;
                    r_est_valid <= 1'b1;
                end
                tcwc_pkg::OP_EST_A: begin
                    r_acc <= (tcwc_pkg::ACC_W'(r_est) << 3) - tcwc_pkg::ACC_W'(r_est);
                end
                tcwc_pkg::OP_EST_B: begin
                    r_est <= tcwc_pkg::RTT_W'((r_acc + tcwc_pkg::ACC_W'(s8)) >> 3);
                end
                tcwc_pkg::OP_DEV_A: begin
                    r_acc  <= (tcwc_pkg::ACC_W'(r_dev) << 1) + tcwc_pkg::ACC_W'(r_dev);
                    r_diff <= (s8 > r_est) ? (s8 - r_est) : (r_est - s8);
                end
                tcwc_pkg::OP_DEV_B: begin
                    r_dev <= tcwc_pkg::RTT_W'((r_acc + tcwc_pkg::ACC_W'(r_diff)) >> 2);
                end
                tcwc_pkg::OP_TMO_A: begin
                    r_acc <= tcwc_pkg::ACC_W'(r_est) + (tcwc_pkg::ACC_W'(r_dev) << 2);
                end
                tcwc_pkg::OP_TMO_B: begin
                    r_timeout <= tmo_clamped;
                end
                default: begin
                end
            endcase
            // Writes load at once; timeout/deviation only before RTT estimate
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    tcwc_pkg::REG_THRESHOLD: r_limit <= cfg_thr;
                    tcwc_pkg::REG_TIMEOUT: begin
                        if (!r_est_valid) begin
                            r_timeout <= cfg_tmo;
                        end
                    end
                    tcwc_pkg::REG_DEVIATION: begin
                        if (!r_est_valid) begin
                            r_dev <= {i_cfg_data[tcwc_pkg::DEV_CW-1:0], 3'b000};
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.op == tcwc_pkg::OP_OUT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.op == tcwc_pkg::OP_OUT && out_free) begin
            r_out_data <= {r_timeout,
                           r_rexmit ? r_ack : tcwc_pkg::ACK_W'(0),
                           r_rexmit,
                           r_phase,
                           r_limit,
                           tcwc_pkg::SLOTS_W'(r_window >> 16),
                           tcwc_pkg::WOUT_W'(r_window)};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

// ----- hw/rtl/tcwc_seq.sv -----
// ----------------------------------------------------------------------------
// TCP congestion window control - microcode sequencer
// Step counter over the control store, with conditional jumps on datapath
// status.
// ----------------------------------------------------------------------------
module tcwc_seq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tcwc_pkg::t_flags i_flags,
    output tcwc_pkg::t_ctrl  o_ctrl
);

    logic [tcwc_pkg::PC_W-1:0] r_pc;
    logic [tcwc_pkg::PC_W-1:0] n_pc;
    tcwc_pkg::t_uword          uw;
    logic                      take;

    // Fetch
    assign uw = tcwc_pkg::urom(r_pc);

    // Branch condition
    always_comb begin
        unique case (uw.cond)
            tcwc_pkg::C_NEVER:      take = 1'b0;
            tcwc_pkg::C_ALWAYS:     take = 1'b1;
            tcwc_pkg::C_NO_ITEM:    take = !i_flags.item_in;
            tcwc_pkg::C_KIND:       take = i_flags.kind;
            tcwc_pkg::C_SLOW:       take = i_flags.slow;
            tcwc_pkg::C_DIV_MORE:   take = i_flags.div_more;
            tcwc_pkg::C_NOT_TRIPLE: take = !i_flags.triple;
            tcwc_pkg::C_NO_DUP:     take = !i_flags.dup;
            tcwc_pkg::C_NO_SAMPLE:  take = !i_flags.sample;
            tcwc_pkg::C_EST_VALID:  take = i_flags.est_valid;
            tcwc_pkg::C_OUT_BUSY:   take = i_flags.out_busy;
            default:                take = 1'b0;
        endcase
        n_pc = take ? uw.target : r_pc + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= tcwc_pkg::P_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_ctrl.op   = uw.op;
    assign o_ctrl.idle = (r_pc == tcwc_pkg::P_IDLE);

endmodule

// ----- hw/rtl/tcwc_check.sv -----
// ----------------------------------------------------------------------------
// TCP congestion window control - port checker
// Watches the top level's ports and flags intake and result items
// that break the block's rules.
// ----------------------------------------------------------------------------
module tcwc_check (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    input  logic                          s_axis_tready,
    input  logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    input  logic [tcwc_pkg::OUT_W-1:0]    m_axis_tdata
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result item changed while stalled");

    // One item at a time: intake closes after an accept
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("item accepted while another is in work");

    // Whole packets are the integer part of the window
    a_slots: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[33:25] == m_axis_tdata[24:16])
        else $error("window_slots differs from window integer part");

    // Resend sequence is zero unless a retransmit is requested
    a_rexmit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[44] |-> m_axis_tdata[76:45] == 32'd0)
        else $error("retransmit_seq set without retransmit");

    // Timeout never reads zero
    a_timeout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[103:77] != 27'd0)
        else $error("timeout_us is zero");

endmodule

bind tcp_congestion_window_control tcwc_check u_tcwc_check (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
